// ===== rtl/ctnc_pkg.sv =====
`timescale 1ns / 1ps
package ctnc_pkg;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [63:0] ALL_ONES   = '1;
  localparam int unsigned DIV_STAGES = 64;

  localparam logic [1:0] CFG_TICK_FREQ  = 2'd0;
  localparam logic [1:0] CFG_RT_OFFSET  = 2'd1;
  localparam logic [1:0] CFG_OFS_VALID  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINIT  = 2'd1,
    ST_OVF     = 2'd2,
    ST_CLAMPED = 2'd3
  } status_e;

  typedef struct packed {
    logic        func;
    logic        realtime_clock;
    logic [63:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] converted_value;
    logic [1:0]  status;
  } out_item_t;

  // Side information that travels with each transaction
  typedef struct packed {
    logic func;
    logic rt;
    logic noinit;
    logic clamp;
    logic ovf;
  } tag_t;

endpackage

// ===== rtl/clock_tick_nanosecond_converter_core.sv =====
`timescale 1ns / 1ps
// Timer tick / nanosecond converter core.
// Input channel (in_valid_i/in_ready_o/in_item_i): one conversion per
// transaction. func 0 turns ticks into ns (ticks*1e9/freq, plus the realtime
// offset on the realtime clock); func 1 turns ns into ticks
// (ns minus offset on realtime, then ns*freq/1e9).
// Output channel (out_valid_o/out_ready_i/out_item_o): one result per
// transaction with a status code (ok, not initialized, overflow, clamped).
// Config channel (cfg_valid_i/cfg_ready_o): register index and 64-bit data;
// always ready. Write only while no conversion is in flight.
// Registered steps from input acceptance to output valid: operand prep,
// 32x32 partial products, 128-bit sum, divider load, 64 restoring divider
// stages (one quotient bit each), result register.
// Throughput: one transaction per cycle when not stalled (pipelined divider).
// Reset clears all stage valid bits and loads freq 1e9, offset 0, offset
// invalid. When the receiver stalls the whole pipe holds in place and
// in_ready_o drops; nothing is lost or repeated.
module clock_tick_nanosecond_converter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ctnc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctnc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  // Config registers
  logic [63:0] freq_q, ofs_q;
  logic        ofs_vld_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q    <= ctnc_pkg::NS_PER_SEC;
      ofs_q     <= '0;
      ofs_vld_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ctnc_pkg::CFG_TICK_FREQ: freq_q    <= cfg_data_i;
        ctnc_pkg::CFG_RT_OFFSET: ofs_q     <= cfg_data_i;
        ctnc_pkg::CFG_OFS_VALID: ofs_vld_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipe moves when the output slot is free or drains
  logic adv;
  logic out_vld_q;
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage A: operand prep
  logic           a_vld_q;
  logic [63:0]    a_op_q, b_op_q;
  ctnc_pkg::tag_t a_tag_q;
  logic [63:0]    a_op_d, b_op_d, ns_d;
  ctnc_pkg::tag_t a_tag_d;
  logic           before_d;

  always_comb begin
    before_d       = in_item_i.operand_value < ofs_q;
    a_tag_d.func   = in_item_i.func;
    a_tag_d.rt     = in_item_i.realtime_clock;
    a_tag_d.noinit = in_item_i.realtime_clock && !ofs_vld_q;
    a_tag_d.clamp  = in_item_i.func && in_item_i.realtime_clock && before_d;
    a_tag_d.ovf    = 1'b0;
    if (!in_item_i.realtime_clock) begin
      ns_d = in_item_i.operand_value;
    end else if (before_d) begin
      ns_d = '0;
    end else begin
      ns_d = in_item_i.operand_value - ofs_q;
    end
    a_op_d = in_item_i.func ? ns_d : in_item_i.operand_value;
    b_op_d = in_item_i.func ? freq_q : ctnc_pkg::NS_PER_SEC;
  end

  // Stage B: partial products
  logic           b_vld_q;
  logic [63:0]    pp00_q, pp01_q, pp10_q, pp11_q;
  ctnc_pkg::tag_t b_tag_q;

  // Stage C: full product
  logic           c_vld_q;
  logic [127:0]   prod_q;
  ctnc_pkg::tag_t c_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_op_q  <= a_op_d;
      b_op_q  <= b_op_d;
      a_tag_q <= a_tag_d;
      pp00_q  <= a_op_q[31:0]  * b_op_q[31:0];
      pp01_q  <= a_op_q[31:0]  * b_op_q[63:32];
      pp10_q  <= a_op_q[63:32] * b_op_q[31:0];
      pp11_q  <= a_op_q[63:32] * b_op_q[63:32];
      b_tag_q <= a_tag_q;
      prod_q  <= {64'd0, pp00_q} + {32'd0, pp01_q, 32'd0}
               + {32'd0, pp10_q, 32'd0} + {pp11_q, 64'd0};
      c_tag_q <= b_tag_q;
    end
  end

  // Quotient needs more than 64 bits exactly when the high half reaches the
  // divisor; a zero divisor lands here too and saturates.
  ctnc_pkg::tag_t div_tag_d;
  logic [63:0]    div_den;
  always_comb begin
    div_den       = c_tag_q.func ? ctnc_pkg::NS_PER_SEC : freq_q;
    div_tag_d     = c_tag_q;
    div_tag_d.ovf = prod_q[127:64] >= div_den;
  end

  logic           e_vld;
  logic [63:0]    e_quo;
  ctnc_pkg::tag_t e_tag;

  ctnc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (c_vld_q),
    .hi_i    (prod_q[127:64]),
    .lo_i    (prod_q[63:0]),
    .tag_i   (div_tag_d),
    .freq_i  (freq_q),
    .valid_o (e_vld),
    .quo_o   (e_quo),
    .tag_o   (e_tag)
  );

  // Result stage: offset add, saturation, status
  ctnc_pkg::out_item_t out_q, out_d;
  logic [64:0]         sum_d;

  always_comb begin
    sum_d = {1'b0, e_quo} + {1'b0, ofs_q};
    if (e_tag.noinit) begin
      out_d.converted_value = '0;
      out_d.status          = ctnc_pkg::ST_NOINIT;
    end else if (e_tag.ovf || (!e_tag.func && e_tag.rt && sum_d[64])) begin
      out_d.converted_value = ctnc_pkg::ALL_ONES;
      out_d.status          = ctnc_pkg::ST_OVF;
    end else if (!e_tag.func) begin
      out_d.converted_value = e_tag.rt ? sum_d[63:0] : e_quo;
      out_d.status          = ctnc_pkg::ST_OK;
    end else begin
      out_d.converted_value = e_quo;
      out_d.status          = e_tag.clamp ? ctnc_pkg::ST_CLAMPED : ctnc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= e_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_noinit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == ctnc_pkg::ST_NOINIT |-> out_q.converted_value == '0)
    else $error("not-initialized result is nonzero");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == ctnc_pkg::ST_OVF
      |-> out_q.converted_value == ctnc_pkg::ALL_ONES)
    else $error("overflow result not saturated");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(out_q))
    else $error("result changed under stall");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input blocked with empty output slot");

endmodule

// ===== rtl/ctnc_div.sv =====
`timescale 1ns / 1ps
module ctnc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [63:0]       hi_i,
  input  logic [63:0]       lo_i,
  input  ctnc_pkg::tag_t    tag_i,
  input  logic [63:0]       freq_i,
  output logic              valid_o,
  output logic [63:0]       quo_o,
  output ctnc_pkg::tag_t    tag_o
);

  logic           vld_q [ctnc_pkg::DIV_STAGES+1];
  logic [63:0]    rem_q [ctnc_pkg::DIV_STAGES+1];
  logic [63:0]    quo_q [ctnc_pkg::DIV_STAGES+1];
  ctnc_pkg::tag_t tag_q [ctnc_pkg::DIV_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= hi_i;
      quo_q[0] <= lo_i;
      tag_q[0] <= tag_i;
    end
  end

  // One quotient bit per stage; remainder < divisor unless ovf
  for (genvar k = 0; k < ctnc_pkg::DIV_STAGES; k++) begin : g_stage
    logic [63:0] div_d;
    logic [64:0] shf_d;
    logic [64:0] dif_d;
    logic        ge_d;

    assign div_d = tag_q[k].func ? ctnc_pkg::NS_PER_SEC : freq_i;
    assign shf_d = {rem_q[k], quo_q[k][63]};
    assign dif_d = shf_d - {1'b0, div_d};
    assign ge_d  = shf_d >= {1'b0, div_d};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1] <= ge_d ? dif_d[63:0] : shf_d[63:0];
        quo_q[k+1] <= {quo_q[k][62:0], ge_d};
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  assign valid_o = vld_q[ctnc_pkg::DIV_STAGES];
  assign quo_o   = quo_q[ctnc_pkg::DIV_STAGES];
  assign tag_o   = tag_q[ctnc_pkg::DIV_STAGES];

endmodule

// ===== tb/tb_clock_tick_nanosecond_converter_core.sv =====
`timescale 1ns / 1ps
module tb_clock_tick_nanosecond_converter_core;

  // Scoreboard: predict each conversion and hold expectations in order.
  class conv_scoreboard;
    logic [63:0]         freq;
    logic [63:0]         offset;
    logic                ofs_ok;
    ctnc_pkg::out_item_t pending[$];
    int                  errors;

    function new();
      freq = ctnc_pkg::NS_PER_SEC;
      offset = '0;
      ofs_ok = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        ctnc_pkg::CFG_TICK_FREQ: freq = data;
        ctnc_pkg::CFG_RT_OFFSET: offset = data;
        ctnc_pkg::CFG_OFS_VALID: ofs_ok = data[0];
        default: ;
      endcase
    endfunction

    function ctnc_pkg::out_item_t convert(ctnc_pkg::in_item_t it);
      ctnc_pkg::out_item_t r;
      logic [127:0] prod;
      logic [127:0] quo;
      logic [64:0]  sum;
      logic [63:0]  ns;
      r.converted_value = '0;
      r.status = ctnc_pkg::ST_OK;
      if (it.realtime_clock && !ofs_ok) begin
        r.status = ctnc_pkg::ST_NOINIT;
      end else if (it.func == 1'b0) begin
        if (freq == 0) begin
          r.converted_value = ctnc_pkg::ALL_ONES;
          r.status = ctnc_pkg::ST_OVF;
        end else begin
          prod = 128'(it.operand_value) * 128'(ctnc_pkg::NS_PER_SEC);
          quo = prod / 128'(freq);
          sum = {1'b0, quo[63:0]} + (it.realtime_clock ? {1'b0, offset} : 65'd0);
          if (quo[127:64] != 0 || sum[64]) begin
            r.converted_value = ctnc_pkg::ALL_ONES;
            r.status = ctnc_pkg::ST_OVF;
          end else begin
            r.converted_value = sum[63:0];
          end
        end
      end else begin
        ns = it.operand_value;
        if (it.realtime_clock) begin
          if (ns >= offset) ns = ns - offset;
          else begin
            ns = '0;
            r.status = ctnc_pkg::ST_CLAMPED;
          end
        end
        prod = 128'(ns) * 128'(freq);
        quo = prod / 128'(ctnc_pkg::NS_PER_SEC);
        if (quo[127:64] != 0) begin
          r.converted_value = ctnc_pkg::ALL_ONES;
          r.status = ctnc_pkg::ST_OVF;
        end else begin
          r.converted_value = quo[63:0];
        end
      end
      return r;
    endfunction

    function void note_input(ctnc_pkg::in_item_t it);
      pending.push_back(convert(it));
    endfunction

    function void check_result(ctnc_pkg::out_item_t got);
      ctnc_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $realtime,
                 got.converted_value, got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.converted_value !== exp_r.converted_value) begin
        $display("%0t: value mismatch expected %h actual %h", $realtime,
                 exp_r.converted_value, got.converted_value);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                 exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  ctnc_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  ctnc_pkg::out_item_t out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [63:0]         cfg_data_i;

  conv_scoreboard sb;
  bit          hold_off;   // set by the stimulus to force a long receiver stall
  bit          stim_done;

  clock_tick_nanosecond_converter_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no gap, else a short one and now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random 64-bit value biased toward edges and small magnitudes.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ctnc_pkg::ALL_ONES;
      2: return 64'($urandom_range(0, 1000));
      3: return {32'h0, $urandom()};
      4: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
      5: return ctnc_pkg::ALL_ONES - 64'($urandom_range(0, 5));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offer one register write; drop valid right after acceptance.
  task automatic write_cfg(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one transaction; hold valid and payload until accepted.
  task automatic send_item(logic f, logic rt, logic [63:0] v, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{func: f, realtime_clock: rt, operand_value: v};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(in_item_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic random_phase(int count);
    logic [63:0] v;
    repeat (count) begin
      v = pick_value();
      // Keep realtime ns near the offset so clamping and subtraction both occur.
      if ($urandom_range(0, 3) == 0) v = sb.offset + 64'($signed($urandom_range(0, 200)) - 100);
      send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), v);
    end
    drain();
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_off = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: compare every output transaction at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  initial begin
    sb = new();
    stim_done = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, realtime before offset is set.
    send_item(1'b0, 1'b0, 64'd0);
    send_item(1'b0, 1'b0, ctnc_pkg::ALL_ONES);
    send_item(1'b1, 1'b0, ctnc_pkg::ALL_ONES);
    send_item(1'b0, 1'b1, 64'd5);
    send_item(1'b1, 1'b1, 64'd5);
    drain();
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, 64'd19200000);
    write_cfg(ctnc_pkg::CFG_RT_OFFSET, 64'd1000);
    write_cfg(ctnc_pkg::CFG_OFS_VALID, 64'd1);
    send_item(1'b0, 1'b1, 64'd19200000);
    send_item(1'b1, 1'b1, 64'd999);          // before offset: clamp
    send_item(1'b1, 1'b1, 64'd1000);
    send_item(1'b1, 1'b1, ctnc_pkg::ALL_ONES);
    send_item(1'b0, 1'b1, ctnc_pkg::ALL_ONES); // overflow
    send_item(1'b0, 1'b0, 64'd1);
    drain();
    write_cfg(ctnc_pkg::CFG_RT_OFFSET, ctnc_pkg::ALL_ONES);
    send_item(1'b0, 1'b1, 64'd1);            // carry out of offset addition
    send_item(1'b0, 1'b1, 64'd0);
    send_item(1'b1, 1'b1, ctnc_pkg::ALL_ONES);
    drain();
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, 64'd0);
    send_item(1'b0, 1'b0, 64'd7);            // zero divisor saturates
    send_item(1'b1, 1'b0, ctnc_pkg::ALL_ONES); // zero product
    drain();
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, ctnc_pkg::ALL_ONES);
    write_cfg(ctnc_pkg::CFG_RT_OFFSET, 64'd0);
    send_item(1'b1, 1'b0, ctnc_pkg::ALL_ONES);
    send_item(1'b0, 1'b0, ctnc_pkg::ALL_ONES);
    send_item(1'b1, 1'b1, 64'd0);
    drain();

    // Random phases across several settings, extremes included.
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, 64'd1);
    random_phase(100);
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, 64'd24000000);
    write_cfg(ctnc_pkg::CFG_RT_OFFSET, {$urandom(), $urandom()} >> 8);
    // Pressure: stall the receiver while the sender keeps offering.
    hold_off = 1;
    repeat (150) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           pick_value(), 1);
    drain();
    write_cfg(ctnc_pkg::CFG_OFS_VALID, 64'd0);
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, {$urandom(), $urandom()});
    random_phase(100);
    write_cfg(ctnc_pkg::CFG_OFS_VALID, 64'd1);
    write_cfg(ctnc_pkg::CFG_RT_OFFSET, ctnc_pkg::ALL_ONES - 64'($urandom_range(0, 1000)));
    random_phase(100);
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, ctnc_pkg::ALL_ONES);
    write_cfg(ctnc_pkg::CFG_RT_OFFSET, {$urandom(), $urandom()});
    random_phase(100);
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, 64'd0);
    random_phase(40);
    write_cfg(ctnc_pkg::CFG_TICK_FREQ, 64'($urandom_range(1, 2000000000)));
    write_cfg(ctnc_pkg::CFG_RT_OFFSET, 64'($urandom()));
    random_phase(110);

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
